/* rtl/core/gcb_pkg.sv */
// Shared types and constants of the glyph coverage bitmap builder.
// No dependencies; the design files refer to it by scoped names, the testbench imports it.
package gcb_pkg;

    localparam int unsigned CP_W      = 16;
    localparam int unsigned METRIC_W  = 32;
    localparam int unsigned WORD_W    = 64;
    localparam int unsigned N_WORDS   = 4;
    localparam int unsigned BLOCK_W   = 8;
    localparam int unsigned SLOT_W    = 8;
    localparam int unsigned COUNT_W   = 9;
    localparam int unsigned BLOCK_LEN = 256;

    localparam logic [METRIC_W-1:0] NO_DEF_MARK = 32'h2000_0000;
    localparam logic [7:0]          BLOCK_END   = 8'hff;

    typedef enum logic [1:0] {
        KIND_EMPTY   = 2'd0,
        KIND_FULL    = 2'd1,
        KIND_PARTIAL = 2'd2
    } kind_t;

    typedef struct packed {
        logic [CP_W-1:0]            code_point;
        logic                       new_font;
        logic signed [METRIC_W-1:0] box_left;
        logic signed [METRIC_W-1:0] box_bottom;
        logic signed [METRIC_W-1:0] box_right;
        logic signed [METRIC_W-1:0] box_top;
        logic signed [METRIC_W-1:0] advance_x;
        logic signed [METRIC_W-1:0] advance_y;
    } item_t;

    typedef logic [N_WORDS-1:0][WORD_W-1:0] bitmap_t;

    typedef struct packed {
        logic [BLOCK_W-1:0] block_number;
        kind_t              kind;
        logic [SLOT_W-1:0]  slot;
        bitmap_t            words;
        logic               exhausted;
    } burst_t;

endpackage

/* rtl/core/gcb_item_if.sv */
// Input channel of the glyph coverage bitmap builder: valid/ready plus one item.
// Depends on gcb_pkg for field widths.
interface gcb_item_if;
    logic                                valid;
    logic                                ready;
    logic [gcb_pkg::CP_W-1:0]            code_point;
    logic                                new_font;
    logic signed [gcb_pkg::METRIC_W-1:0] box_left;
    logic signed [gcb_pkg::METRIC_W-1:0] box_bottom;
    logic signed [gcb_pkg::METRIC_W-1:0] box_right;
    logic signed [gcb_pkg::METRIC_W-1:0] box_top;
    logic signed [gcb_pkg::METRIC_W-1:0] advance_x;
    logic signed [gcb_pkg::METRIC_W-1:0] advance_y;

    modport source (
        output valid, code_point, new_font, box_left, box_bottom, box_right, box_top,
               advance_x, advance_y,
        input  ready
    );
    modport sink (
        input  valid, code_point, new_font, box_left, box_bottom, box_right, box_top,
               advance_x, advance_y,
        output ready
    );
endinterface

/* rtl/core/gcb_result_if.sv */
// Result channel of the glyph coverage bitmap builder: valid/ready plus one result.
// Depends on gcb_pkg for field widths.
interface gcb_result_if;
    logic                              valid;
    logic                              ready;
    logic [gcb_pkg::BLOCK_W-1:0]       block_number;
    logic [1:0]                        block_kind;
    logic [gcb_pkg::SLOT_W-1:0]        slot;
    logic [1:0]                        word_index;
    logic [gcb_pkg::WORD_W-1:0]        bitmap_word;
    logic                              slots_exhausted;
    logic                              last;

    modport source (
        output valid, block_number, block_kind, slot, word_index, bitmap_word,
               slots_exhausted, last,
        input  ready
    );
    modport sink (
        input  valid, block_number, block_kind, slot, word_index, bitmap_word,
               slots_exhausted, last,
        output ready
    );
endinterface

/* rtl/core/glyph_coverage_bitmap_builder.sv */
// Glyph coverage bitmap builder: accepts one code point per clock unless a block end
// waits as below, and classifies it as present or absent from its box and advance. A
// code point with low byte 0xff closes its 256-code block: an empty or full block
// yields a single result beat, any other block four beats carrying the 64-bit bitmap
// words under the next slot number. An accepted item passes the input register, then
// the result register, before its first result beat. Items flow at one per cycle; the
// result register drains one beat per cycle while results.ready is high, so a block end
// waits in the input register until the previous block's last beat is taken. Once
// MAX_SLOTS slots are used, items are dropped without results until new_font is set.
// Depends on gcb_pkg, gcb_item_if, gcb_result_if, gcb_accum and gcb_burst.
module glyph_coverage_bitmap_builder #(
    parameter int unsigned MAX_SLOTS = 254
) (
    input  logic          clk,
    input  logic          rst_n,
    gcb_item_if.sink      items,
    gcb_result_if.source  results
);

    logic             burst_free;
    logic             burst_load;
    gcb_pkg::burst_t  burst_data;

    gcb_accum #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .items      (items),
        .burst_free (burst_free),
        .burst_load (burst_load),
        .burst_data (burst_data)
    );

    gcb_burst u_burst (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (burst_load),
        .data    (burst_data),
        .free    (burst_free),
        .results (results)
    );

endmodule

/* rtl/core/gcb_classify.sv */
// Glyph presence test from bounding box, advance and space-character set.
// Depends on gcb_pkg (item_t, NO_DEF_MARK).
module gcb_classify (
    input  gcb_pkg::item_t item,
    output logic           present
);

    logic box_zero;
    logic adv_zero;
    logic space_char;

    always_comb
    begin
        box_zero   = (item.box_left == '0) && (item.box_bottom == '0) &&
                     (item.box_right == '0) && (item.box_top == '0);
        adv_zero   = (item.advance_x == '0) && (item.advance_y == '0);
        space_char = (item.code_point == 16'h0020) || (item.code_point == 16'h00a0) ||
                     ((item.code_point >= 16'h2000) && (item.code_point <= 16'h200b)) ||
                     (item.code_point == 16'h202f) || (item.code_point == 16'h3000);
        present    = !(item.box_left == gcb_pkg::NO_DEF_MARK) &&
                     !(box_zero && adv_zero) &&
                     !(box_zero && !space_char);
    end

endmodule

/* rtl/core/gcb_accum.sv */
// Input register, block buffer, present count, slot counter and stop flag.
// Depends on gcb_pkg, gcb_item_if and gcb_classify; hands finished blocks to gcb_burst.
module gcb_accum #(
    parameter int unsigned MAX_SLOTS = 254
) (
    input  logic              clk,
    input  logic              rst_n,
    gcb_item_if.sink          items,
    input  logic              burst_free,
    output logic              burst_load,
    output gcb_pkg::burst_t   burst_data
);

    gcb_pkg::item_t                   item_reg;
    logic                             item_valid_reg;
    gcb_pkg::bitmap_t                 bits_reg,  bits_next;
    logic [gcb_pkg::COUNT_W-1:0]      count_reg, count_next;
    logic [gcb_pkg::SLOT_W-1:0]       slots_reg, slots_next;
    logic                             stopped_reg, stopped_next;

    logic                             present;
    logic                             take;
    logic                             gen_result;
    logic                             block_end;
    logic [1:0]                       widx;
    logic [5:0]                       bidx;
    gcb_pkg::bitmap_t                 bits_eff, bits_upd;
    logic [gcb_pkg::COUNT_W-1:0]      count_eff, count_upd;
    logic [gcb_pkg::SLOT_W-1:0]       slots_eff, slots_inc;
    logic                             stopped_eff;
    logic                             hit;

    gcb_classify u_classify (
        .item    (item_reg),
        .present (present)
    );

    always_comb
    begin
        widx        = item_reg.code_point[7:6];
        bidx        = item_reg.code_point[5:0];
        block_end   = (item_reg.code_point[7:0] == gcb_pkg::BLOCK_END);

        bits_eff    = item_reg.new_font ? '0 : bits_reg;
        count_eff   = item_reg.new_font ? '0 : count_reg;
        slots_eff   = item_reg.new_font ? '0 : slots_reg;
        stopped_eff = item_reg.new_font ? 1'b0 : stopped_reg;

        hit         = bits_eff[widx][bidx];
        bits_upd    = bits_eff;
        if (present)
        begin
            bits_upd[widx][bidx] = 1'b1;
        end
        count_upd   = count_eff + gcb_pkg::COUNT_W'(present && !hit);
        slots_inc   = slots_eff + 1'b1;

        gen_result  = item_valid_reg && !stopped_eff && block_end;
        take        = item_valid_reg && (!gen_result || burst_free);
        burst_load  = take && gen_result;

        burst_data.block_number = item_reg.code_point[15:8];
        burst_data.kind         = gcb_pkg::KIND_PARTIAL;
        burst_data.slot         = slots_eff;
        burst_data.words        = bits_upd;
        burst_data.exhausted    = (slots_inc == gcb_pkg::SLOT_W'(MAX_SLOTS));
        if (count_upd == '0)
        begin
            burst_data.kind      = gcb_pkg::KIND_EMPTY;
            burst_data.slot      = '0;
            burst_data.words     = '0;
            burst_data.exhausted = 1'b0;
        end
        else if (count_upd >= gcb_pkg::COUNT_W'(gcb_pkg::BLOCK_LEN))
        begin
            burst_data.kind      = gcb_pkg::KIND_FULL;
            burst_data.slot      = '0;
            burst_data.words     = '0;
            burst_data.exhausted = 1'b0;
        end

        bits_next    = bits_reg;
        count_next   = count_reg;
        slots_next   = slots_reg;
        stopped_next = stopped_reg;
        if (take && !stopped_eff)
        begin
            bits_next    = bits_upd;
            count_next   = count_upd;
            slots_next   = slots_eff;
            stopped_next = 1'b0;
            if (block_end)
            begin
                bits_next  = '0;
                count_next = '0;
                if (burst_data.kind == gcb_pkg::KIND_PARTIAL)
                begin
                    slots_next   = slots_inc;
                    stopped_next = burst_data.exhausted;
                end
            end
        end

        items.ready = !item_valid_reg || take;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            bits_reg       <= '0;
            count_reg      <= '0;
            slots_reg      <= '0;
            stopped_reg    <= 1'b0;
        end
        else
        begin
            if (items.ready)
            begin
                item_valid_reg <= items.valid;
            end
            bits_reg    <= bits_next;
            count_reg   <= count_next;
            slots_reg   <= slots_next;
            stopped_reg <= stopped_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (items.ready && items.valid)
        begin
            item_reg.code_point <= items.code_point;
            item_reg.new_font   <= items.new_font;
            item_reg.box_left   <= items.box_left;
            item_reg.box_bottom <= items.box_bottom;
            item_reg.box_right  <= items.box_right;
            item_reg.box_top    <= items.box_top;
            item_reg.advance_x  <= items.advance_x;
            item_reg.advance_y  <= items.advance_y;
        end
    end

endmodule

/* rtl/core/gcb_burst.sv */
// Result register and beat sequencer: one beat for empty or full, four for a bitmap.
// Depends on gcb_pkg and gcb_result_if.
module gcb_burst (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  gcb_pkg::burst_t   data,
    output logic              free,
    gcb_result_if.source      results
);

    gcb_pkg::burst_t  burst_reg;
    logic             valid_reg, valid_next;
    logic [1:0]       word_reg,  word_next;
    logic             last_beat;
    logic             beat_done;

    always_comb
    begin
        last_beat  = (burst_reg.kind != gcb_pkg::KIND_PARTIAL) || (word_reg == 2'd3);
        beat_done  = valid_reg && results.ready;
        free       = !valid_reg || (beat_done && last_beat);

        valid_next = valid_reg;
        word_next  = word_reg;
        if (beat_done)
        begin
            if (last_beat)
            begin
                valid_next = 1'b0;
                word_next  = '0;
            end
            else
            begin
                word_next = word_reg + 1'b1;
            end
        end
        if (load)
        begin
            valid_next = 1'b1;
            word_next  = '0;
        end

        results.valid           = valid_reg;
        results.block_number    = burst_reg.block_number;
        results.block_kind      = burst_reg.kind;
        results.slot            = burst_reg.slot;
        results.word_index      = word_reg;
        results.bitmap_word     = burst_reg.words[word_reg];
        results.slots_exhausted = burst_reg.exhausted;
        results.last            = last_beat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            word_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            word_reg  <= word_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            burst_reg <= data;
        end
    end

endmodule

/* sim/tb_top.sv */
// Testbench for glyph_coverage_bitmap_builder: a directed table, then random block runs
// and a run to slot exhaustion, checked beat by beat against a local predictor.
// Depends on gcb_pkg, gcb_item_if, gcb_result_if and the block itself.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gcb_pkg::*;

    localparam int unsigned SLOT_LIMIT   = 254;
    localparam int          LIMIT_CYCLES = 200000;
    localparam int          HOLD_CYCLES  = 80;
    localparam int          TAIL_CYCLES  = 20;
    localparam int          MAX_REPORTS  = 10;
    localparam logic [31:0] M_MIN        = 32'h8000_0000;
    localparam logic [31:0] M_MAX        = 32'h7fff_ffff;
    localparam logic [31:0] M_ONES       = 32'hffff_ffff;

    typedef struct packed {
        logic [BLOCK_W-1:0] block_number;
        kind_t              kind;
        logic [SLOT_W-1:0]  slot;
        logic [1:0]         word_index;
        logic [WORD_W-1:0]  bitmap_word;
        logic               exhausted;
        logic               last;
    } beat_t;

    typedef struct packed {
        item_t it;
        logic  typed;
        kind_t kind;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    gcb_item_if   item_ch ();
    gcb_result_if result_ch ();

    glyph_coverage_bitmap_builder #(
        .MAX_SLOTS(SLOT_LIMIT)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .items  (item_ch),
        .results(result_ch)
    );

    always #5 clk = ~clk;

    // predictor state
    logic [COUNT_W-1:0] cov_count;
    bitmap_t            cov_bits;
    logic [SLOT_W-1:0]  slots_taken;
    bit                 scan_stopped;

    beat_t pending[$];
    bit    idling = 1'b1;
    bit    hold_req = 1'b0;
    bit    hold_on = 1'b0;
    int    items_sent = 0;
    int    beats_seen = 0;
    int    fails = 0;
    int    n_empty = 0;
    int    n_full = 0;
    int    n_partial = 0;
    int    n_exhaust = 0;

    function automatic bit blank_char(logic [CP_W-1:0] cp);
        return cp == 16'h0020 || cp == 16'h00a0 || (cp >= 16'h2000 && cp <= 16'h200b) ||
               cp == 16'h202f || cp == 16'h3000;
    endfunction

    function automatic bit has_glyph(item_t it);
        bit empty_box;
        empty_box = it.box_left == 0 && it.box_bottom == 0 && it.box_right == 0 &&
                    it.box_top == 0;
        if (it.box_left == NO_DEF_MARK)
            return 1'b0;
        if (empty_box && it.advance_x == 0 && it.advance_y == 0)
            return 1'b0;
        if (empty_box && !blank_char(it.code_point))
            return 1'b0;
        return 1'b1;
    endfunction

    function automatic void coverage_step(input item_t it, output beat_t beats[$]);
        int                 w;
        int                 b;
        logic [BLOCK_W-1:0] blk;
        logic [SLOT_W-1:0]  slot;
        logic               ex;
        beats = {};
        if (it.new_font)
        begin
            cov_count    = '0;
            cov_bits     = '0;
            slots_taken  = '0;
            scan_stopped = 1'b0;
        end
        if (scan_stopped)
            return;
        if (has_glyph(it))
        begin
            w = int'(it.code_point[7:6]);
            b = int'(it.code_point[5:0]);
            if (!cov_bits[w][b])
            begin
                cov_bits[w][b] = 1'b1;
                cov_count++;
            end
        end
        if (it.code_point[7:0] != BLOCK_END)
            return;
        blk = it.code_point[15:8];
        if (cov_count == 0)
            beats.push_back(beat_t'{blk, KIND_EMPTY, 8'd0, 2'd0, 64'd0, 1'b0, 1'b1});
        else if (cov_count >= BLOCK_LEN)
            beats.push_back(beat_t'{blk, KIND_FULL, 8'd0, 2'd0, 64'd0, 1'b0, 1'b1});
        else
        begin
            slot = slots_taken;
            slots_taken++;
            ex = (slots_taken == SLOT_LIMIT);
            for (w = 0; w < N_WORDS; w++)
                beats.push_back(beat_t'{blk, KIND_PARTIAL, slot, 2'(w), cov_bits[w], ex,
                                        w == N_WORDS - 1});
            if (ex)
                scan_stopped = 1'b1;
        end
        cov_count = '0;
        cov_bits  = '0;
    endfunction

    function automatic string beat_str(beat_t b);
        return $sformatf("block %02h kind %0d slot %0d word %0d bits %016h exh %0b last %0b",
                         b.block_number, b.kind, b.slot, b.word_index, b.bitmap_word,
                         b.exhausted, b.last);
    endfunction

    function automatic row_t glyph_row(logic [15:0] cp, bit nf, logic [31:0] x0,
                                       logic [31:0] y0, logic [31:0] x1, logic [31:0] y1,
                                       logic [31:0] ax, logic [31:0] ay, bit typed = 1'b0,
                                       kind_t k = KIND_EMPTY);
        row_t r;
        r.it    = '{cp, nf, x0, y0, x1, y1, ax, ay};
        r.typed = typed;
        r.kind  = k;
        return r;
    endfunction

    function automatic logic [31:0] rand_metric();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return M_MIN;
            2: return M_MAX;
            3: return M_ONES;
            default: return $urandom;
        endcase
    endfunction

    function automatic item_t random_glyph(logic [15:0] cp, bit nf);
        int    cls;
        item_t it;
        it            = '0;
        it.code_point = cp;
        it.new_font   = nf;
        cls           = $urandom_range(0, 19);
        if (cls < 3)
        begin
            it.box_left   = NO_DEF_MARK;
            it.box_bottom = rand_metric();
            it.box_right  = rand_metric();
            it.box_top    = rand_metric();
            it.advance_x  = rand_metric();
            it.advance_y  = rand_metric();
        end
        else if (cls < 10 && cls >= 6)
        begin
            it.advance_x = $urandom_range(0, 1) ? rand_metric() : 32'd0;
            it.advance_y = $urandom_range(0, 1) ? rand_metric() : 32'd0;
        end
        else if (cls >= 10)
        begin
            it.box_left   = rand_metric();
            it.box_bottom = rand_metric();
            it.box_right  = rand_metric();
            it.box_top    = rand_metric();
            it.advance_x  = rand_metric();
            it.advance_y  = rand_metric();
        end
        return it;
    endfunction

    function automatic item_t solid_glyph(logic [15:0] cp, bit nf);
        item_t it;
        it            = random_glyph(cp, nf);
        it.box_left   = $urandom_range(1, 32'h1fff_ffff);
        it.box_bottom = $urandom;
        it.box_right  = $urandom;
        it.box_top    = $urandom;
        return it;
    endfunction

    task automatic feed(input item_t it, input bit typed = 1'b0, input kind_t k = KIND_EMPTY);
        beat_t beats[$];
        if (idling && $urandom_range(0, 4) == 0)
        begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        item_ch.valid      <= 1'b1;
        item_ch.code_point <= it.code_point;
        item_ch.new_font   <= it.new_font;
        item_ch.box_left   <= it.box_left;
        item_ch.box_bottom <= it.box_bottom;
        item_ch.box_right  <= it.box_right;
        item_ch.box_top    <= it.box_top;
        item_ch.advance_x  <= it.advance_x;
        item_ch.advance_y  <= it.advance_y;
        do @(posedge clk); while (!item_ch.ready);
        coverage_step(it, beats);
        if (typed)
            beats = '{beat_t'{it.code_point[15:8], k, 8'd0, 2'd0, 64'd0, 1'b0, 1'b1}};
        foreach (beats[i])
            pending.push_back(beats[i]);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic drain_wait();
        item_ch.valid <= 1'b0;
        do @(negedge clk); while (pending.size() != 0);
    endtask

    task automatic feed_run();
        logic [7:0] blk;
        int         lo;
        bit         nf;
        bit         dense;
        case ($urandom_range(0, 7))
            0: blk = 8'h00;
            1: blk = 8'h20;
            2: blk = 8'h30;
            default: blk = 8'($urandom_range(0, 255));
        endcase
        dense = blk == 8'h00 || blk == 8'h20 || blk == 8'h30;
        nf    = $urandom_range(0, 9) == 0;
        lo    = $urandom_range(0, 15);
        while (lo < 255)
        begin
            feed(random_glyph({blk, 8'(lo)}, nf));
            nf = 1'b0;
            lo += (dense && lo < 'h30) ? $urandom_range(1, 5) : $urandom_range(8, 90);
        end
        if ($urandom_range(0, 9) != 0)
            feed(random_glyph({blk, BLOCK_END}, nf));
        if ($urandom_range(0, 7) == 0)
            feed(random_glyph(16'($urandom), 1'b0));
    endtask

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("glyph_coverage_bitmap_builder test failed");
        $finish;
    end

    initial
    begin : hold_off
        wait (hold_req);
        hold_on = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_on = 1'b0;
    end

    initial
    begin : result_drain
        int gap;
        gap = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_on)
                result_ch.ready <= 1'b0;
            else if (gap > 0)
            begin
                result_ch.ready <= 1'b0;
                gap--;
            end
            else if (idling && $urandom_range(0, 5) == 0)
            begin
                result_ch.ready <= 1'b0;
                gap = $urandom_range(0, 2);
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : result_check
        beat_t got;
        beat_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got.block_number = result_ch.block_number;
            got.kind         = kind_t'(result_ch.block_kind);
            got.slot         = result_ch.slot;
            got.word_index   = result_ch.word_index;
            got.bitmap_word  = result_ch.bitmap_word;
            got.exhausted    = result_ch.slots_exhausted;
            got.last         = result_ch.last;
            beats_seen++;
            if (got.last)
            begin
                case (got.kind)
                    KIND_EMPTY:   n_empty++;
                    KIND_FULL:    n_full++;
                    KIND_PARTIAL: n_partial++;
                    default: ;
                endcase
                if (got.exhausted)
                    n_exhaust++;
            end
            if (pending.size() == 0)
            begin
                fails++;
                if (fails <= MAX_REPORTS)
                    $display("unexpected beat: %s", beat_str(got));
            end
            else
            begin
                want = pending.pop_front();
                if (got !== want)
                begin
                    fails++;
                    if (fails <= MAX_REPORTS)
                        $display("mismatch\n  expected %s\n  actual   %s",
                                 beat_str(want), beat_str(got));
                end
            end
        end
    end

    initial
    begin : stimulus
        row_t       plan[$];
        logic [7:0] blk;
        int         target;
        cov_count          = '0;
        cov_bits           = '0;
        slots_taken        = '0;
        scan_stopped       = 1'b0;
        item_ch.valid      = 1'b0;
        item_ch.code_point = '0;
        item_ch.new_font   = 1'b0;
        item_ch.box_left   = '0;
        item_ch.box_bottom = '0;
        item_ch.box_right  = '0;
        item_ch.box_top    = '0;
        item_ch.advance_x  = '0;
        item_ch.advance_y  = '0;

        plan = '{
            glyph_row(16'h0000, 1, 0, 0, 0, 0, 0, 0),
            glyph_row(16'h0020, 0, 0, 0, 0, 0, 500, 0),
            glyph_row(16'h0041, 0, NO_DEF_MARK, M_MAX, M_MAX, M_MAX, M_MAX, M_MAX),
            glyph_row(16'h0042, 0, M_MIN, M_MIN, M_MAX, M_MAX, M_MIN, M_MIN),
            glyph_row(16'h0042, 0, M_MIN, M_MIN, M_MAX, M_MAX, M_MIN, M_MIN),
            glyph_row(16'h0043, 0, 0, 0, 0, 0, 100, 0),
            glyph_row(16'h00a0, 0, 0, 0, 0, 0, 0, M_ONES),
            glyph_row(16'h00ff, 0, 0, 0, 0, 0, 0, 0),
            glyph_row(16'h01ff, 0, NO_DEF_MARK, 0, 0, 0, 0, 0, 1, KIND_EMPTY),
            glyph_row(16'h2000, 0, 0, 0, 0, 0, 1, 0),
            glyph_row(16'h200b, 0, 0, 0, 0, 0, 1, 1),
            glyph_row(16'h200c, 0, 0, 0, 0, 0, 1, 0),
            glyph_row(16'h202f, 0, 0, 0, 0, 0, M_MIN, 0),
            glyph_row(16'h20ff, 0, M_ONES, M_ONES, M_ONES, M_ONES, M_ONES, M_ONES),
            glyph_row(16'h3000, 0, 0, 0, 0, 0, 0, 1),
            glyph_row(16'h30ff, 0, 32'h1fff_ffff, 0, 0, 0, 0, 0),
            glyph_row(16'h3fff, 0, 0, 0, 0, 0, 0, 0, 1, KIND_EMPTY),
            glyph_row(16'h41c0, 0, 0, 1, 0, 0, 0, 0),
            glyph_row(16'h4000, 0, 0, 0, 1, 0, 0, 0),
            glyph_row(16'h55ff, 0, 0, 0, 0, 1, 0, 0),
            glyph_row(16'hffff, 1, 10, 32'hffff_fffb, 600, 700, 650, 0),
            glyph_row(16'h1234, 1, M_MAX, M_MAX, M_MAX, M_MAX, M_MAX, M_MAX),
            glyph_row(16'h12ff, 0, NO_DEF_MARK, 0, 0, 0, 0, 0)
        };

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (plan[i])
            feed(plan[i].it, plan[i].typed, plan[i].kind);
        drain_wait();

        while (items_sent < 40)
        begin
            idling = $urandom_range(0, 3) != 0;
            feed_run();
        end

        idling = 1'b1;

        // pause until every beat is out, then flood bitmap blocks into a stalled output
        drain_wait();
        hold_req = 1'b1;
        feed(solid_glyph({8'($urandom), BLOCK_END}, 1'b1));
        while (!scan_stopped)
        begin
            blk = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 15) == 0)
                feed(random_glyph({blk, 8'($urandom_range(0, 254))}, 1'b0));
            feed(solid_glyph({blk, BLOCK_END}, 1'b0));
        end
        repeat (12)
            feed(random_glyph({8'($urandom), $urandom_range(0, 1) ? BLOCK_END : 8'($urandom)},
                              1'b0));
        feed(random_glyph(16'($urandom), 1'b1));

        idling = 1'b0;
        target = items_sent + 30;
        while (items_sent < target)
            feed_run();

        item_ch.valid <= 1'b0;
        do @(negedge clk); while (pending.size() != 0);
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("%0d items fed, %0d result beats checked, %0d mismatching or unexpected",
                 items_sent, beats_seen, fails);
        $display("blocks seen: %0d empty, %0d full, %0d bitmap, %0d slot exhaustions",
                 n_empty, n_full, n_partial, n_exhaust);
        if (fails == 0 && pending.size() == 0)
            $display("glyph_coverage_bitmap_builder test passed");
        else
            $display("glyph_coverage_bitmap_builder test failed");
        $finish;
    end

endmodule
